### hw/rtl/pcse_pkg.sv
package pcse_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [1:0] {
    KIND_SKIP,
    KIND_PUSH,
    KIND_OPER
  } kind_t;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  typedef struct packed {
    kind_t      kind;
    op_t        op;
    logic [7:0] char_byte;
    logic       last;
  } item_t;

endpackage

### hw/rtl/postfix_char_stack_evaluator.sv
// Flow: a character is registered in the front, then held in the queue until
//   the execute sequencer takes it; a result leaves through the output register.
// The execute sequencer handles one character at a time and the divide runs 8
//   steps; the front keeps taking characters while the queue has room.
// Reset (rst_n low, synchronous): empties the queue, stack count and error flag;
//   stack contents are not cleared.
module postfix_char_stack_evaluator import pcse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_expr,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value,
  output logic [2:0] out_status
);

  // Front to queue: one classified character per transfer.
  item_t front_item;
  logic  front_valid;
  logic  q_full;

  // Queue to execute side.
  item_t q_head;
  logic  q_nonempty;
  logic  q_pop;

  // Front: register the incoming transfer and decode it into skip, push or
  // one of the four operators. Hold the input while the register waits on a full queue.
  pcse_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_in     (in_char_in),
    .in_end_of_expr (in_end_of_expr),
    .item_valid     (front_valid),
    .item           (front_item),
    .q_full         (q_full)
  );

  // Short queue: lets the front keep taking characters while a divide or a
  // stalled result holds the execute side.
  pcse_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (front_valid),
    .push_item (front_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .nonempty  (q_nonempty)
  );

  // Execute side: stack memory with the top kept in a register, a sequencer
  // that reads the second operand, applies the operator (bit-serial divide)
  // and writes back, plus the output register that carries the final result.
  // The first error of an expression is kept; drop every later character
  // until the end flag, then report and clear the stack for the next one.
  pcse_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_nonempty (q_nonempty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule

### hw/rtl/pcse_front.sv
module pcse_front import pcse_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_end_of_expr,
  output logic       item_valid,
  output item_t      item,
  input  logic       q_full
);

  item_t item_r;
  item_t item_nxt;
  logic  item_valid_r;
  logic  accept;
  logic  push;

  // Classify the character once, here, so the back end only decodes a kind.
  always_comb begin
    item_nxt.char_byte = in_char_in;
    item_nxt.last      = in_end_of_expr;
    item_nxt.kind      = KIND_PUSH;
    item_nxt.op        = OP_ADD;
    case (in_char_in)
      CH_SPACE: item_nxt.kind = KIND_SKIP;
      CH_PLUS: begin
        item_nxt.kind = KIND_OPER;
        item_nxt.op   = OP_ADD;
      end
      CH_MINUS: begin
        item_nxt.kind = KIND_OPER;
        item_nxt.op   = OP_SUB;
      end
      CH_STAR: begin
        item_nxt.kind = KIND_OPER;
        item_nxt.op   = OP_MUL;
      end
      CH_SLASH: begin
        item_nxt.kind = KIND_OPER;
        item_nxt.op   = OP_DIV;
      end
      default: item_nxt.kind = KIND_PUSH;
    endcase
  end

  assign in_stall   = item_valid_r && q_full;
  assign accept     = in_valid && !in_stall;
  assign push       = item_valid_r && !q_full;
  assign item_valid = item_valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (accept) begin
      item_valid_r <= 1'b1;
    end else if (push) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

### hw/rtl/pcse_queue.sv
module pcse_queue import pcse_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output item_t head,
  output logic  nonempty
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t           q_mem_r [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_r;
  logic [PW-1:0]   rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push;
  logic            do_pop;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign nonempty = (count_r != '0);
  assign head     = q_mem_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

### hw/rtl/pcse_exec.sv
module pcse_exec import pcse_pkg::*; #(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_nonempty,
  input  item_t      q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_value,
  output logic [2:0] out_status
);

  localparam int IW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_DIV,
    S_WRITE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_DIVZERO   = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  logic [7:0] stack_mem [STACK_DEPTH];

  state_t          state_r;
  item_t           cur_r;
  logic [CW-1:0]   count_r;
  status_t         error_r;
  logic [7:0]      tos_r;
  logic [7:0]      res_r;
  logic [7:0]      rd_data_r;
  logic [7:0]      dvd_r;
  logic [7:0]      rem_r;
  logic [7:0]      dvs_r;
  logic            neg_r;
  logic [2:0]      iter_r;
  logic            out_valid_r;
  logic [7:0]      out_value_r;
  status_t         out_status_r;

  logic [CW-1:0]   cnt_m2;
  logic            mem_we;
  logic [IW-1:0]   mem_waddr;
  logic [7:0]      mem_wdata;
  logic            out_free;
  logic            out_load;

  logic signed [8:0]  opa;
  logic signed [8:0]  opb;
  logic signed [8:0]  sum;
  logic signed [8:0]  diff;
  logic signed [17:0] prod;
  logic [8:0]         opa_abs;
  logic [8:0]         opb_abs;
  logic [7:0]         alu_byte;
  logic [8:0]         rem_sh;
  logic               ge;
  logic [8:0]         rem_sub;
  logic [7:0]         q_fin;

  function automatic logic signed [8:0] operand_of(input logic [7:0] b);
    return $signed({b[7], b}) - 9'sd48;
  endfunction

  assign cnt_m2   = count_r - CW'(2);
  assign out_free = !out_valid_r || !out_stall;
  assign out_load = (state_r == S_DONE) && cur_r.last && out_free;
  assign q_pop    = (state_r == S_IDLE) && q_nonempty;

  // Operand decode and the combinational operators (add, subtract, multiply).
  always_comb begin
    opa     = operand_of(rd_data_r);
    opb     = operand_of(tos_r);
    sum     = opa + opb;
    diff    = opa - opb;
    prod    = opa * opb;
    opa_abs = opa[8] ? -opa : opa;
    opb_abs = opb[8] ? -opb : opb;
    case (cur_r.op)
      OP_ADD:  alu_byte = sum[7:0] + CH_ZERO;
      OP_SUB:  alu_byte = diff[7:0] + CH_ZERO;
      OP_MUL:  alu_byte = prod[7:0] + CH_ZERO;
      default: alu_byte = CH_ZERO;
    endcase
  end

  // One restoring divide step on magnitudes.
  always_comb begin
    rem_sh  = {rem_r, dvd_r[7]};
    ge      = (rem_sh >= {1'b0, dvs_r});
    rem_sub = rem_sh - {1'b0, dvs_r};
    q_fin   = {dvd_r[6:0], ge};
  end

  // Stack write port: push of a plain character, or the operator result
  // landing where the left operand was.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = count_r[IW-1:0];
    mem_wdata = cur_r.char_byte;
    if (state_r == S_EXEC && error_r == ST_OK && cur_r.kind == KIND_PUSH &&
        count_r != CW'(STACK_DEPTH)) begin
      mem_we = 1'b1;
    end else if (state_r == S_WRITE) begin
      mem_we    = 1'b1;
      mem_waddr = cnt_m2[IW-1:0];
      mem_wdata = res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= stack_mem[cnt_m2[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      error_r     <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_nonempty) begin
            cur_r   <= q_head;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (error_r == ST_OK) begin
            case (cur_r.kind)
              KIND_PUSH: begin
                state_r <= S_DONE;
                if (count_r == CW'(STACK_DEPTH)) begin
                  error_r <= ST_OVERFLOW;
                end else begin
                  count_r <= count_r + CW'(1);
                  tos_r   <= cur_r.char_byte;
                end
              end
              KIND_OPER: begin
                if (count_r < CW'(2)) begin
                  error_r <= ST_UNDERFLOW;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_READ;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end else begin
            state_r <= S_DONE;
          end
        end
        S_READ: begin
          if (cur_r.op == OP_DIV) begin
            if (opb == 9'sd0) begin
              error_r <= ST_DIVZERO;
              state_r <= S_DONE;
            end else begin
              dvd_r   <= opa_abs[7:0];
              dvs_r   <= opb_abs[7:0];
              rem_r   <= '0;
              neg_r   <= opa[8] ^ opb[8];
              iter_r  <= '0;
              state_r <= S_DIV;
            end
          end else begin
            res_r   <= alu_byte;
            state_r <= S_WRITE;
          end
        end
        S_DIV: begin
          rem_r  <= ge ? rem_sub[7:0] : rem_sh[7:0];
          dvd_r  <= q_fin;
          iter_r <= iter_r + 3'd1;
          if (iter_r == 3'd7) begin
            res_r   <= (neg_r ? -q_fin : q_fin) + CH_ZERO;
            state_r <= S_WRITE;
          end
        end
        S_WRITE: begin
          count_r <= count_r - CW'(1);
          tos_r   <= res_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!cur_r.last) begin
            state_r <= S_IDLE;
          end else if (out_free) begin
            if (error_r != ST_OK) begin
              out_status_r <= error_r;
              out_value_r  <= 8'h00;
            end else if (count_r == '0) begin
              out_status_r <= ST_EMPTY;
              out_value_r  <= 8'h00;
            end else begin
              out_status_r <= ST_OK;
              out_value_r  <= tos_r;
            end
            count_r <= '0;
            error_r <= ST_OK;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_value_r;
  assign out_status = 3'(out_status_r);

endmodule

### verif/postfix_char_stack_evaluator_test.sv
`timescale 1ns / 1ps

module postfix_char_stack_evaluator_test;
  import pcse_pkg::*;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;

  // Result status codes as the block reports them.
  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_UNDERFLOW = 3'd1;
  localparam logic [2:0] STAT_DIVZERO   = 3'd2;
  localparam logic [2:0] STAT_OVERFLOW  = 3'd3;
  localparam logic [2:0] STAT_EMPTY     = 3'd4;

  // Item budget, idle rate, drain time and the run limit in clock cycles.
  localparam int RANDOM_ITEMS = 650;
  localparam int IDLE_PCT     = 6;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  typedef logic [7:0] char_q_t [$];

  // Evaluate each accepted character on a private copy of the stack and
  // hold one expected result per end-of-expression character.
  class expr_scoreboard;
    logic [7:0]  stk [STACK_DEPTH];
    int unsigned depth;
    logic [2:0]  err;
    logic [7:0]  exp_value [$];
    logic [2:0]  exp_status [$];
    int          failures;
    int          results;
    int          status_seen [8];

    function new();
      depth    = 0;
      err      = STAT_OK;
      failures = 0;
      results  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return exp_value.size();
    endfunction

    function int operand(logic [7:0] b);
      return int'($signed(b)) - 48;
    endfunction

    function void push_byte(logic [7:0] b);
      if (depth >= STACK_DEPTH) begin
        err = STAT_OVERFLOW;
        return;
      end
      stk[depth] = b;
      depth++;
    endfunction

    function void apply_char(logic [7:0] c);
      int a;
      int b;
      int r;
      if (c == CH_SPACE) return;
      if (c != CH_PLUS && c != CH_MINUS && c != CH_STAR && c != CH_SLASH) begin
        push_byte(c);
        return;
      end
      if (depth < 2) begin
        err = STAT_UNDERFLOW;
        return;
      end
      b = operand(stk[depth - 1]);
      a = operand(stk[depth - 2]);
      case (c)
        CH_PLUS:  r = a + b;
        CH_MINUS: r = a - b;
        CH_STAR:  r = a * b;
        default: begin
          if (b == 0) begin
            err = STAT_DIVZERO;
            return;
          end
          r = a / b;
        end
      endcase
      depth -= 2;
      push_byte(8'(r + 48));
    endfunction

    function void note_input(logic [7:0] c, logic last);
      if (err == STAT_OK) apply_char(c);
      if (!last) return;
      if (err != STAT_OK) begin
        exp_value.push_back(8'h00);
        exp_status.push_back(err);
      end else if (depth == 0) begin
        exp_value.push_back(8'h00);
        exp_status.push_back(STAT_EMPTY);
      end else begin
        exp_value.push_back(stk[depth - 1]);
        exp_status.push_back(STAT_OK);
      end
      depth = 0;
      err   = STAT_OK;
    endfunction

    function void check_result(logic [7:0] value, logic [2:0] status);
      logic [7:0] ev;
      logic [2:0] es;
      if (exp_value.size() == 0) begin
        $error("unexpected result: value %02h status %0d", value, status);
        failures++;
        return;
      end
      ev = exp_value.pop_front();
      es = exp_status.pop_front();
      results++;
      status_seen[es]++;
      if (value !== ev) begin
        $error("value: expected %02h, got %02h", ev, value);
        failures++;
      end
      if (status !== es) begin
        $error("status: expected %0d, got %0d", es, status);
        failures++;
      end
    endfunction
  endclass

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in     = 8'h00;
  logic       in_end_of_expr = 1'b0;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_value;
  logic [2:0] out_status;

  expr_scoreboard sb = new();

  int  chars_sent = 0;
  int  exprs_sent = 0;
  // Quiet window: neither side idles while this is set.
  logic quiet = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  postfix_char_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char_in    (in_char_in),
    .in_end_of_expr(in_end_of_expr),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_value     (out_value),
    .out_status    (out_status)
  );

  // Watch both channels at the edge; values seen here are the ones that held
  // when the transfer happened.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_char_in, in_end_of_expr);
      if (out_valid && !out_stall) sb.check_result(out_value, out_status);
    end
  end

  // Stall the result side now and then, except inside the quiet window.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Hard stop if the block hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Present one character and hold it until the transfer; outside the quiet
  // window, drop valid first at random.
  task automatic send_char(input logic [7:0] c, input logic last);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_in     <= c;
    in_end_of_expr <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (c != CH_SPACE) chars_sent++;
    quiet = (chars_sent >= 300) && (chars_sent < 420);
  endtask

  // Send a whole expression, flagging its final character.
  task automatic send_expr(input char_q_t chars);
    foreach (chars[i]) send_char(chars[i], i == chars.size() - 1);
    exprs_sent++;
  endtask

  function automatic logic [7:0] pick_oper();
    logic [7:0] opers [4];
    opers = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};
    return opers[$urandom_range(0, 3)];
  endfunction

  // Mostly digits; sometimes any byte that is not an operator or a space.
  function automatic logic [7:0] pick_operand();
    logic [7:0] b;
    if ($urandom_range(0, 99) < 85) return CH_ZERO + 8'($urandom_range(0, 9));
    b = 8'($urandom_range(0, 255));
    if (b == CH_SPACE || b == CH_PLUS || b == CH_MINUS || b == CH_STAR || b == CH_SLASH)
      b = CH_ZERO + 8'($urandom_range(0, 9));
    return b;
  endfunction

  // Build a well-formed postfix expression with random shape and spaces.
  function automatic char_q_t build_wellformed(int max_live, int n_operands);
    char_q_t q;
    int live;
    int pushed;
    live   = 0;
    pushed = 0;
    while (pushed < n_operands || live > 1) begin
      if (pushed < n_operands && (live < 2 || (live < max_live && $urandom_range(0, 1)))) begin
        q.push_back(pick_operand());
        live++;
        pushed++;
      end else begin
        q.push_back(pick_oper());
        live--;
      end
      if ($urandom_range(0, 9) == 0) q.push_back(CH_SPACE);
    end
    return q;
  endfunction

  // Push all operands first, then fold; runs past the stack depth when long.
  function automatic char_q_t build_deep(int n_operands);
    char_q_t q;
    for (int i = 0; i < n_operands; i++) q.push_back(pick_operand());
    for (int i = 1; i < n_operands; i++) q.push_back(pick_oper());
    return q;
  endfunction

  // Random characters: operators, operands and spaces in any order, or raw bytes.
  function automatic char_q_t build_noise(bit raw);
    char_q_t q;
    int len;
    int sel;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      sel = $urandom_range(0, 2);
      if (raw)           q.push_back(8'($urandom_range(0, 255)));
      else if (sel == 0) q.push_back(pick_oper());
      else if (sel == 1) q.push_back(CH_SPACE);
      else               q.push_back(pick_operand());
    end
    return q;
  endfunction

  initial begin
    char_q_t q;
    int pick;
    int limit_items;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: byte extremes with subtract, a plain divide, divide by zero,
    // underflow followed by characters that must be ignored, multiply,
    // an expression with nothing left on the stack, and a full stack overrun.
    send_expr('{8'hFF, 8'h00, CH_MINUS});
    send_expr('{CH_ZERO + 8'd7, CH_ZERO + 8'd2, CH_SLASH});
    send_expr('{CH_ZERO + 8'd5, CH_ZERO, CH_SLASH});
    send_expr('{CH_ZERO + 8'd3, CH_PLUS, CH_ZERO + 8'd4});
    send_expr('{CH_ZERO + 8'd3, CH_ZERO + 8'd4, CH_STAR});
    send_expr('{CH_SPACE});
    q = {};
    for (int i = 0; i <= STACK_DEPTH; i++) q.push_back(CH_ZERO + 8'(i % 10));
    send_expr(q);

    // Random: mostly well-formed expressions, some deep ones, the rest
    // broken sequences and raw noise.
    limit_items = chars_sent + RANDOM_ITEMS;
    while (chars_sent < limit_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)      q = build_wellformed($urandom_range(2, 6), $urandom_range(1, 5));
      else if (pick < 76) q = build_deep($urandom_range(12, STACK_DEPTH + 2));
      else if (pick < 88) q = build_noise(1'b0);
      else                q = build_noise(1'b1);
      send_expr(q);
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Let every expected result arrive, then give the pipeline time to
    // show anything spurious.
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.pending() != 0) begin
      $error("%0d expected results never arrived", sb.pending());
      sb.failures++;
    end

    $display("covered %0d characters in %0d expressions, %0d results checked",
             chars_sent, exprs_sent, sb.results);
    $display("status mix: ok %0d, underflow %0d, div-by-zero %0d, overflow %0d, empty %0d",
             sb.status_seen[STAT_OK], sb.status_seen[STAT_UNDERFLOW],
             sb.status_seen[STAT_DIVZERO], sb.status_seen[STAT_OVERFLOW],
             sb.status_seen[STAT_EMPTY]);
    if (sb.failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
